>>> design/idel_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the indexed double-ended list unit
package idel_pkg;

    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_DATA_WIDTH = 32;

    localparam logic [3:0] FN_PUSH_FRONT = 4'd0;
    localparam logic [3:0] FN_POP_FRONT  = 4'd1;
    localparam logic [3:0] FN_PUSH_BACK  = 4'd2;
    localparam logic [3:0] FN_POP_BACK   = 4'd3;
    localparam logic [3:0] FN_INSERT     = 4'd4;
    localparam logic [3:0] FN_REMOVE     = 4'd5;
    localparam logic [3:0] FN_GET        = 4'd6;
    localparam logic [3:0] FN_FWD_BEGIN  = 4'd7;
    localparam logic [3:0] FN_FWD_NEXT   = 4'd8;
    localparam logic [3:0] FN_REV_BEGIN  = 4'd9;
    localparam logic [3:0] FN_REV_NEXT   = 4'd10;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_END   = 2'd3;

    typedef struct packed {
        logic [3:0]  func;
        logic [6:0]  position;
        logic [31:0] data_in;
    } req_item_t;

    typedef struct packed {
        logic [31:0] data_out;
        logic [1:0]  status;
        logic [6:0]  count;
    } resp_item_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     rd_en;
    } cell_ctrl_t;

endpackage

>>> design/indexed_double_ended_list_unit.sv
`timescale 1ns / 1ps
// top level of the indexed double-ended list unit
// one request in flight: a new request is taken only once the last one's response is registered
// decode in the accept cycle into the control registers, then in the execute state,
// once the response side is free, every cell of the chain shifts in parallel and the read is taken
// reset clears length and both cursors; stored words are undefined until written
module indexed_double_ended_list_unit #(
    parameter int CAPACITY   = idel_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = idel_pkg::DEF_DATA_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  idel_pkg::req_item_t   req,
    output logic                  resp_valid,
    input  logic                  resp_ready,
    output idel_pkg::resp_item_t  resp
);
    import idel_pkg::*;

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int WW = (LW > 7) ? LW : 7;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t              state_reg;
    logic [LW-1:0]       length_reg;
    logic [LW-1:0]       length_next;
    logic [LW-1:0]       fwd_reg;
    logic [LW-1:0]       fwd_next;
    logic [LW-1:0]       rev_reg;
    logic [LW-1:0]       rev_next;
    cell_op_t            op_reg;
    cell_op_t            op_next;
    logic                rd_en_reg;
    logic                rd_en_next;
    logic [IW-1:0]       at_reg;
    logic [WW-1:0]       at_next;
    logic [DATA_WIDTH-1:0] din_reg;
    logic [1:0]          stat_reg;
    logic [1:0]          stat_next;
    logic                resp_valid_reg;
    resp_item_t          resp_reg;

    logic                accept;
    logic                fire;
    logic [WW-1:0]       len_w;
    logic [WW-1:0]       pos_w;
    logic [WW-1:0]       fwd_w;
    logic [WW-1:0]       rev_w;
    cell_ctrl_t          ctrl;
    logic [DATA_WIDTH-1:0] words [CAPACITY];
    logic [DATA_WIDTH-1:0] taps  [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_word;

    assign req_ready  = (state_reg == S_IDLE);
    assign accept     = req_valid && req_ready;
    assign fire       = (state_reg == S_EXEC) && (!resp_valid_reg || resp_ready);
    assign resp_valid = resp_valid_reg;
    assign resp       = resp_reg;

    assign len_w = WW'(length_reg);
    assign pos_w = WW'(req.position);
    assign fwd_w = WW'(fwd_reg);
    assign rev_w = WW'(rev_reg);

    // request decode and bookkeeping of length and cursors
    always_comb
    begin
        length_next = length_reg;
        fwd_next    = fwd_reg;
        rev_next    = rev_reg;
        op_next     = CELL_HOLD;
        rd_en_next  = 1'b0;
        at_next     = pos_w;
        stat_next   = ST_OK;
        unique case (req.func)
            FN_PUSH_FRONT, FN_PUSH_BACK, FN_INSERT:
            begin
                if (req.func == FN_PUSH_FRONT)
                    at_next = '0;
                else if (req.func == FN_PUSH_BACK)
                    at_next = len_w;
                if (length_reg == LW'(CAPACITY))
                    stat_next = ST_FULL;
                else if (at_next > len_w)
                    stat_next = ST_EMPTY;
                else
                begin
                    op_next     = CELL_INSERT;
                    length_next = length_reg + LW'(1);
                    if (fwd_reg != '0 && fwd_w > at_next)
                        fwd_next = fwd_reg + LW'(1);
                    if (rev_reg != '0 && rev_w > at_next)
                        rev_next = rev_reg + LW'(1);
                end
            end
            FN_POP_FRONT, FN_POP_BACK, FN_REMOVE, FN_GET:
            begin
                if (req.func == FN_POP_FRONT)
                    at_next = '0;
                else if (req.func == FN_POP_BACK)
                    at_next = len_w - WW'(1);
                if (length_reg == '0 || at_next >= len_w)
                    stat_next = ST_EMPTY;
                else
                begin
                    rd_en_next = 1'b1;
                    if (req.func != FN_GET)
                    begin
                        op_next     = CELL_REMOVE;
                        length_next = length_reg - LW'(1);
                        if (fwd_reg != '0)
                        begin
                            if (fwd_w > at_next + WW'(1))
                                fwd_next = fwd_reg - LW'(1);
                            else if (fwd_w == at_next + WW'(1) && fwd_w == len_w)
                                fwd_next = '0;
                        end
                        if (rev_reg != '0)
                        begin
                            if (rev_w > at_next + WW'(1))
                                rev_next = rev_reg - LW'(1);
                            else if (rev_w == at_next + WW'(1))
                                rev_next = LW'(at_next);
                        end
                    end
                end
            end
            FN_FWD_BEGIN:
            begin
                fwd_next = (length_reg != '0) ? LW'(1) : '0;
            end
            FN_FWD_NEXT:
            begin
                if (fwd_reg == '0 || fwd_reg > length_reg)
                begin
                    fwd_next  = '0;
                    stat_next = ST_END;
                end
                else
                begin
                    rd_en_next = 1'b1;
                    at_next    = fwd_w - WW'(1);
                    fwd_next   = (fwd_reg == length_reg) ? '0 : fwd_reg + LW'(1);
                end
            end
            FN_REV_BEGIN:
            begin
                rev_next = length_reg;
            end
            FN_REV_NEXT:
            begin
                if (rev_reg == '0 || rev_reg > length_reg)
                begin
                    rev_next  = '0;
                    stat_next = ST_END;
                end
                else
                begin
                    rd_en_next = 1'b1;
                    at_next    = rev_w - WW'(1);
                    rev_next   = rev_reg - LW'(1);
                end
            end
            default:
            begin
                stat_next = ST_OK;
            end
        endcase
    end

    assign ctrl.op    = fire ? op_reg : CELL_HOLD;
    assign ctrl.rd_en = rd_en_reg;

    // chain of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_w;
        logic [DATA_WIDTH-1:0] right_w;
        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = words[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = words[i+1];
        end
        idel_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IW),
            .IDX        (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .at         (at_reg),
            .din        (din_reg),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (words[i]),
            .tap        (taps[i])
        );
    end

    always_comb
    begin
        rd_word = '0;
        for (int k = 0; k < CAPACITY; k++)
            rd_word = rd_word | taps[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            length_reg     <= '0;
            fwd_reg        <= '0;
            rev_reg        <= '0;
            op_reg         <= CELL_HOLD;
            rd_en_reg      <= 1'b0;
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
                resp_valid_reg <= 1'b1;
            else if (resp_ready)
                resp_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        length_reg <= length_next;
                        fwd_reg    <= fwd_next;
                        rev_reg    <= rev_next;
                        op_reg     <= op_next;
                        rd_en_reg  <= rd_en_next;
                        at_reg     <= IW'(at_next);
                        din_reg    <= DATA_WIDTH'(req.data_in);
                        stat_reg   <= stat_next;
                        state_reg  <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (fire)
                    begin
                        resp_reg.data_out <= 32'(rd_word);
                        resp_reg.status   <= stat_reg;
                        resp_reg.count    <= 7'(length_reg);
                        op_reg            <= CELL_HOLD;
                        rd_en_reg         <= 1'b0;
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= LW'(CAPACITY))
        else $error("length above capacity");

    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg <= length_reg && rev_reg <= length_reg)
        else $error("cursor beyond list end");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in flight");

endmodule

>>> design/idel_cell.sv
`timescale 1ns / 1ps
// one storage cell of the list: holds a word and shifts with its neighbors
module idel_cell #(
    parameter int DATA_WIDTH = idel_pkg::DEF_DATA_WIDTH,
    parameter int IDX_W      = 6,
    parameter int IDX        = 0
) (
    input  logic                  clk,
    input  idel_pkg::cell_ctrl_t  ctrl,
    input  logic [IDX_W-1:0]      at,
    input  logic [DATA_WIDTH-1:0] din,
    input  logic [DATA_WIDTH-1:0] left_word,
    input  logic [DATA_WIDTH-1:0] right_word,
    output logic [DATA_WIDTH-1:0] word,
    output logic [DATA_WIDTH-1:0] tap
);
    import idel_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [DATA_WIDTH-1:0] word_reg;
    logic [DATA_WIDTH-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        unique case (ctrl.op)
            CELL_INSERT:
            begin
                if (MY_IDX > at)
                    word_next = left_word;
                else if (MY_IDX == at)
                    word_next = din;
            end
            CELL_REMOVE:
            begin
                if (MY_IDX >= at)
                    word_next = right_word;
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;
    assign tap  = (ctrl.rd_en && (MY_IDX == at)) ? word_reg : '0;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the indexed double-ended list unit
module tb;
    import idel_pkg::*;

    localparam int CAP        = DEF_CAPACITY;
    localparam int N_ITEMS    = 1250;
    localparam int TAIL_ITEMS = 120;
    localparam int DRAIN_AT   = 400;
    localparam int HOLD_AT    = 700;
    localparam int HOLD_LEN   = 150;
    localparam int WDOG_LIMIT = 4000;

    localparam logic [3:0] FN_UNUSED_LO = 4'd11;
    localparam logic [3:0] FN_UNUSED_HI = 4'd15;

    typedef enum {MIX_OPS, FILL_OPS, DRAIN_OPS} op_mix_t;

    typedef struct packed {
        req_item_t item;
        logic      drain_first;
    } pend_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    req_item_t  req = '0;
    logic       resp_valid;
    logic       resp_ready = 1'b0;
    resp_item_t resp;

    pend_t      req_q[$];
    resp_item_t resp_q[$];

    // list state tracked for prediction
    logic [31:0] lst_words [CAP];
    int          lst_len = 0;
    int          fwd_pos = 0;
    int          rev_pos = 0;

    int gen_len = 0;
    int n_items = N_ITEMS;
    int resp_cnt = 0;
    int bad = 0;
    int wdog = 0;

    int         tx_gap, tx_cycle, tx_pct;
    logic       drive_valid;
    resp_item_t want;
    int         rx_gap, rx_cycle, rx_pct, rx_hold;
    bit         hold_done;
    logic       drive_ready;
    resp_item_t want_out;

    indexed_double_ended_list_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .resp       (resp)
    );

    always #2 clk = ~clk;

    task automatic list_apply(input req_item_t it, output resp_item_t r);
        int at;
        int k;
        r = '0;
        r.status = ST_OK;
        case (it.func)
            FN_PUSH_FRONT, FN_PUSH_BACK, FN_INSERT:
            begin
                if (lst_len >= CAP)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    at = (it.func == FN_PUSH_FRONT) ? 0 :
                         (it.func == FN_PUSH_BACK) ? lst_len : int'(it.position);
                    if (at > lst_len)
                    begin
                        r.status = ST_EMPTY;
                    end
                    else
                    begin
                        for (k = lst_len; k > at; k--)
                            lst_words[k] = lst_words[k-1];
                        lst_words[at] = it.data_in;
                        lst_len++;
                        if (fwd_pos != 0 && fwd_pos - 1 >= at)
                            fwd_pos++;
                        if (rev_pos != 0 && rev_pos - 1 >= at)
                            rev_pos++;
                    end
                end
            end
            FN_POP_FRONT, FN_POP_BACK, FN_REMOVE, FN_GET:
            begin
                at = (it.func == FN_POP_FRONT) ? 0 :
                     (it.func == FN_POP_BACK) ? lst_len - 1 : int'(it.position);
                if (lst_len == 0 || at >= lst_len)
                begin
                    r.status = ST_EMPTY;
                end
                else if (it.func == FN_GET)
                begin
                    r.data_out = lst_words[at];
                end
                else
                begin
                    r.data_out = lst_words[at];
                    for (k = at; k < lst_len - 1; k++)
                        lst_words[k] = lst_words[k+1];
                    lst_len--;
                    // removed element: forward moves on, reverse moves back
                    if (fwd_pos != 0)
                    begin
                        if (fwd_pos - 1 > at)
                            fwd_pos--;
                        else if (fwd_pos - 1 == at && at >= lst_len)
                            fwd_pos = 0;
                    end
                    if (rev_pos != 0)
                    begin
                        if (rev_pos - 1 > at)
                            rev_pos--;
                        else if (rev_pos - 1 == at)
                            rev_pos = at;
                    end
                end
            end
            FN_FWD_BEGIN:
            begin
                fwd_pos = (lst_len > 0) ? 1 : 0;
            end
            FN_FWD_NEXT:
            begin
                if (fwd_pos == 0 || fwd_pos > lst_len)
                begin
                    fwd_pos = 0;
                    r.status = ST_END;
                end
                else
                begin
                    r.data_out = lst_words[fwd_pos-1];
                    fwd_pos++;
                    if (fwd_pos > lst_len)
                        fwd_pos = 0;
                end
            end
            FN_REV_BEGIN:
            begin
                rev_pos = lst_len;
            end
            FN_REV_NEXT:
            begin
                if (rev_pos == 0 || rev_pos > lst_len)
                begin
                    rev_pos = 0;
                    r.status = ST_END;
                end
                else
                begin
                    r.data_out = lst_words[rev_pos-1];
                    rev_pos--;
                end
            end
            default:
            begin
            end
        endcase
        r.count = 7'(lst_len);
    endtask

    function automatic req_item_t mk(logic [3:0] f, int pos, logic [31:0] d);
        req_item_t it;
        it.func     = f;
        it.position = 7'(pos);
        it.data_in  = d;
        return it;
    endfunction

    function automatic req_item_t rand_req(op_mix_t mix);
        req_item_t it;
        int r;
        r = $urandom_range(0, 99);
        it.data_in  = $urandom;
        it.position = 7'($urandom_range(0, CAP));
        it.func     = 4'($urandom_range(0, 10));
        if (mix == FILL_OPS)
        begin
            if (r < 35)
                it.func = FN_PUSH_BACK;
            else if (r < 60)
                it.func = FN_PUSH_FRONT;
            else if (r < 85)
                it.func = FN_INSERT;
        end
        else if (mix == DRAIN_OPS)
        begin
            if (r < 30)
                it.func = FN_POP_FRONT;
            else if (r < 55)
                it.func = FN_POP_BACK;
            else if (r < 85)
                it.func = FN_REMOVE;
        end
        // mostly in-range positions, some out of range
        if (it.func == FN_INSERT && $urandom_range(0, 99) < 85)
            it.position = 7'($urandom_range(0, gen_len));
        else if ((it.func == FN_REMOVE || it.func == FN_GET) && gen_len > 0
                 && $urandom_range(0, 99) < 85)
            it.position = 7'($urandom_range(0, gen_len - 1));
        return it;
    endfunction

    task automatic add_req(req_item_t it);
        pend_t p;
        p.item        = it;
        p.drain_first = (req_q.size() == DRAIN_AT);
        req_q.push_back(p);
        case (it.func)
            FN_PUSH_FRONT, FN_PUSH_BACK:
                if (gen_len < CAP)
                    gen_len++;
            FN_INSERT:
                if (gen_len < CAP && it.position <= gen_len)
                    gen_len++;
            FN_POP_FRONT, FN_POP_BACK:
                if (gen_len > 0)
                    gen_len--;
            FN_REMOVE:
                if (it.position < gen_len)
                    gen_len--;
            default:
            begin
            end
        endcase
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            tx_gap    = 0;
            tx_cycle  = 0;
            tx_pct    = 0;
        end
        else
        begin
            drive_valid = req_valid;
            tx_cycle++;
            if (tx_cycle % 83 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: tx_pct = 0;
                    1: tx_pct = 10;
                    default: tx_pct = 45;
                endcase
            end
            if (req_q.size() < TAIL_ITEMS)
                tx_pct = 0;
            if (req_valid && req_ready)
            begin
                list_apply(req, want);
                resp_q.push_back(want);
                drive_valid = 1'b0;
            end
            if (!drive_valid && req_q.size() != 0)
            begin
                if (tx_gap > 0)
                    tx_gap--;
                else if (req_q[0].drain_first && resp_q.size() != 0)
                    tx_gap = 0;
                else if ($urandom_range(0, 99) < tx_pct)
                    tx_gap = $urandom_range(0, 14);
                else
                begin
                    drive_valid = 1'b1;
                    req <= req_q[0].item;
                    req_q.delete(0);
                end
            end
            req_valid <= drive_valid;
        end
    end

    // response side back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resp_ready <= 1'b0;
            rx_gap    = 0;
            rx_cycle  = 0;
            rx_pct    = 0;
            rx_hold   = 0;
            hold_done = 1'b0;
        end
        else
        begin
            rx_cycle++;
            if (rx_cycle % 97 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: rx_pct = 0;
                    1: rx_pct = 15;
                    default: rx_pct = 50;
                endcase
            end
            if (resp_cnt >= n_items - TAIL_ITEMS)
                rx_pct = 0;
            if (rx_hold > 0)
            begin
                rx_hold--;
                drive_ready = 1'b0;
            end
            else if (!hold_done && resp_cnt >= HOLD_AT)
            begin
                // long stall so the unit backs up into the request side
                rx_hold     = HOLD_LEN;
                hold_done   = 1'b1;
                drive_ready = 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                drive_ready = 1'b0;
            end
            else if ($urandom_range(0, 99) < rx_pct)
            begin
                rx_gap      = $urandom_range(0, 14);
                drive_ready = 1'b0;
            end
            else
            begin
                drive_ready = 1'b1;
            end
            resp_ready <= drive_ready;
        end
    end

    // response checker
    always @(posedge clk)
    begin
        if (rst_n && resp_valid && resp_ready)
        begin
            resp_cnt++;
            if (resp_q.size() == 0)
            begin
                bad++;
                if (bad <= 10)
                    $display("unexpected response %0d: data %h status %0d count %0d",
                             resp_cnt, resp.data_out, resp.status, resp.count);
            end
            else
            begin
                want_out = resp_q[0];
                resp_q.delete(0);
                if (resp.data_out !== want_out.data_out || resp.status !== want_out.status
                    || resp.count !== want_out.count)
                begin
                    bad++;
                    if (bad <= 10)
                        $display("mismatch on response %0d: exp data %h status %0d",
                                 resp_cnt, want_out.data_out, want_out.status,
                                 " count %0d, got data %h status %0d count %0d",
                                 want_out.count, resp.data_out, resp.status, resp.count);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (resp_valid && resp_ready))
                wdog = 0;
            else
                wdog++;
            if (wdog >= WDOG_LIMIT)
            begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        int seg;
        bit walk_fwd;

        // empty list corner cases
        add_req(mk(FN_POP_FRONT, 0, 32'h0));
        add_req(mk(FN_POP_BACK, 0, 32'h0));
        add_req(mk(FN_REMOVE, 0, 32'h0));
        add_req(mk(FN_GET, 0, 32'h0));
        add_req(mk(FN_FWD_NEXT, 0, 32'h0));
        add_req(mk(FN_REV_NEXT, 0, 32'h0));
        add_req(mk(FN_FWD_BEGIN, 0, 32'h0));
        add_req(mk(FN_REV_BEGIN, 0, 32'h0));
        // build a short list, with bad insert index
        add_req(mk(FN_PUSH_BACK, 0, 32'hFFFF_FFFF));
        add_req(mk(FN_PUSH_FRONT, 127, 32'h0000_0000));
        add_req(mk(FN_INSERT, 1, 32'hA5A5_A5A5));
        add_req(mk(FN_INSERT, 5, 32'h1111_1111));
        add_req(mk(FN_INSERT, 3, 32'h5A5A_5A5A));
        add_req(mk(FN_GET, 64, 32'h0));
        add_req(mk(FN_GET, 2, 32'h0));
        // cursors following inserts and removes of their own element
        add_req(mk(FN_FWD_BEGIN, 0, 32'h0));
        add_req(mk(FN_REV_BEGIN, 0, 32'h0));
        add_req(mk(FN_REMOVE, 0, 32'h0));
        add_req(mk(FN_INSERT, 0, 32'h1234_5678));
        add_req(mk(FN_FWD_NEXT, 0, 32'h0));
        add_req(mk(FN_REMOVE, 3, 32'h0));
        add_req(mk(FN_REMOVE, 2, 32'h0));
        add_req(mk(FN_REV_NEXT, 0, 32'h0));
        // undefined function codes
        add_req(mk(FN_UNUSED_LO, 64, 32'hDEAD_BEEF));
        add_req(mk(FN_UNUSED_HI, 0, 32'h0));

        seg = 0;
        while (req_q.size() < N_ITEMS)
        begin
            case (seg % 4)
                0:
                begin
                    n = 0;
                    while (gen_len < CAP && n < 150)
                    begin
                        add_req(rand_req(FILL_OPS));
                        n++;
                    end
                    repeat (4) add_req(rand_req(FILL_OPS));
                end
                2:
                begin
                    n = 0;
                    while (gen_len > 0 && n < 150)
                    begin
                        add_req(rand_req(DRAIN_OPS));
                        n++;
                    end
                    repeat (3) add_req(rand_req(DRAIN_OPS));
                end
                default:
                begin
                    repeat ($urandom_range(30, 80))
                    begin
                        if ($urandom_range(0, 99) < 15)
                        begin
                            // cursor walk with edits mixed in
                            walk_fwd = $urandom_range(0, 1);
                            add_req(mk(walk_fwd ? FN_FWD_BEGIN : FN_REV_BEGIN,
                                       $urandom_range(0, CAP), $urandom));
                            repeat ($urandom_range(2, 10))
                            begin
                                if ($urandom_range(0, 99) < 75)
                                    add_req(mk(walk_fwd ? FN_FWD_NEXT : FN_REV_NEXT,
                                               $urandom_range(0, CAP), $urandom));
                                else
                                    add_req(rand_req(MIX_OPS));
                            end
                        end
                        else
                        begin
                            add_req(rand_req(MIX_OPS));
                        end
                    end
                end
            endcase
            seg++;
        end
        n_items = req_q.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (req_q.size() != 0 || req_valid || resp_q.size() != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);

        if (bad == 0 && resp_q.size() == 0 && resp_cnt == n_items)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
